### sv/mlrf_pkg.sv
// Package for the masked linear regression fit unit.
// Widths, frame snapshot type and solver constants; used by all modules.
package mlrf_pkg;
  localparam int MAX_DIM = 1024;
  localparam int DIM_W = $clog2(MAX_DIM);
  localparam int CFG_W = 11;
  localparam int HALF_W = 4;
  localparam int PIX_W = 16;
  localparam int CNT_W = 2 * DIM_W + 1;
  localparam int SUM1_W = 37;
  localparam int SUM2_W = 52;
  localparam int LIMB_W = SUM2_W / 2;
  localparam int ACC_W = 108;
  localparam int DET_W = 72;
  localparam int NUM_MAG_W = 87;
  localparam int FRAC_W = 16;
  localparam int DIVN_W = NUM_MAG_W + FRAC_W + 1;
  localparam int QDEPTH = 2;
  localparam int OUT_W = 32;

  localparam logic [1:0] REG_WIDTH = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_HALF = 2'd2;

  localparam logic [CFG_W-1:0] RST_WIDTH = CFG_W'(128);
  localparam logic [CFG_W-1:0] RST_HEIGHT = CFG_W'(128);
  localparam logic [HALF_W-1:0] RST_HALF = HALF_W'(2);

  typedef struct packed {
    logic [CNT_W-1:0]         n;
    logic signed [SUM1_W-1:0] sf;
    logic signed [SUM1_W-1:0] sz;
    logic signed [SUM2_W-1:0] sfz;
    logic signed [SUM2_W-1:0] sff;
  } sums_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;
endpackage

### sv/mlrf_front.sv
// Front end: raster counters, centre mask, products and frame accumulators.
// Depends on mlrf_pkg. Pushes one sums snapshot per finished frame.
module mlrf_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       clear_i,
  input  logic [mlrf_pkg::CFG_W-1:0] width_i,
  input  logic [mlrf_pkg::CFG_W-1:0] height_i,
  input  logic [mlrf_pkg::HALF_W-1:0] half_i,
  input  logic                       push_i,
  output logic                       full_o,
  input  logic signed [mlrf_pkg::PIX_W-1:0] model_pixel_i,
  input  logic signed [mlrf_pkg::PIX_W-1:0] data_pixel_i,
  input  mlrf_pkg::qstat_t           qstat_i,
  output logic                       q_push_o,
  output mlrf_pkg::sums_t            q_data_o
);
  localparam int CW = mlrf_pkg::CFG_W;
  localparam int DW = mlrf_pkg::DIM_W;

  logic [DW-1:0] col_q, col_d, row_q, row_d;
  logic [CW-1:0] w_eff, h_eff;
  logic signed [CW:0] dc, dr, s_pos, s_neg;
  logic masked, last, accept, consume;
  logic signed [mlrf_pkg::PIX_W-1:0] f_m, z_m;
  logic vld_q, last_q;
  logic signed [mlrf_pkg::PIX_W-1:0] f_q, z_q;
  logic signed [2*mlrf_pkg::PIX_W-1:0] ff_q, fz_q;
  mlrf_pkg::sums_t acc_q, acc_nx;

  always_comb begin
    w_eff = width_i;
    if (width_i == '0) w_eff = CW'(1);
    else if (width_i > CW'(mlrf_pkg::MAX_DIM)) w_eff = CW'(mlrf_pkg::MAX_DIM);
    h_eff = height_i;
    if (height_i == '0) h_eff = CW'(1);
    else if (height_i > CW'(mlrf_pkg::MAX_DIM)) h_eff = CW'(mlrf_pkg::MAX_DIM);
  end

  always_comb begin
    dc = $signed({2'b00, col_q}) - $signed({1'b0, w_eff[CW-1:1]});
    dr = $signed({2'b00, row_q}) - $signed({1'b0, h_eff[CW-1:1]});
    s_pos = $signed({{(CW+1-mlrf_pkg::HALF_W){1'b0}}, half_i});
    s_neg = -s_pos;
    masked = (dc >= s_neg) && (dc <= s_pos) && (dr >= s_neg) && (dr <= s_pos);
    f_m = masked ? '0 : model_pixel_i;
    z_m = masked ? '0 : data_pixel_i;
  end

  always_comb begin
    last = 1'b0;
    col_d = col_q;
    row_d = row_q;
    if (({1'b0, col_q} + CW'(1)) >= w_eff) begin
      col_d = '0;
      if (({1'b0, row_q} + CW'(1)) >= h_eff) begin
        last = 1'b1;
        row_d = '0;
      end else begin
        row_d = row_q + DW'(1);
      end
    end else begin
      col_d = col_q + DW'(1);
    end
  end

  assign consume = vld_q && !(last_q && qstat_i.full);
  assign full_o = vld_q && !consume;
  assign accept = push_i && !full_o;

  always_comb begin
    acc_nx.n = acc_q.n + mlrf_pkg::CNT_W'(1);
    acc_nx.sf = acc_q.sf + mlrf_pkg::SUM1_W'(f_q);
    acc_nx.sz = acc_q.sz + mlrf_pkg::SUM1_W'(z_q);
    acc_nx.sfz = acc_q.sfz + mlrf_pkg::SUM2_W'(fz_q);
    acc_nx.sff = acc_q.sff + mlrf_pkg::SUM2_W'(ff_q);
  end

  assign q_push_o = consume && last_q;
  assign q_data_o = acc_nx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      vld_q <= 1'b0;
      last_q <= 1'b0;
      acc_q <= '0;
    end else if (clear_i) begin
      col_q <= '0;
      row_q <= '0;
      vld_q <= 1'b0;
      last_q <= 1'b0;
      acc_q <= '0;
    end else begin
      if (consume) acc_q <= last_q ? '0 : acc_nx;
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
        vld_q <= 1'b1;
        last_q <= last;
      end else if (consume) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      f_q <= f_m;
      z_q <= z_m;
      ff_q <= f_m * f_m;
      fz_q <= f_m * z_m;
    end
  end
endmodule

### sv/mlrf_queue.sv
// Two-entry queue of frame sums between accumulators and solver.
// Depends on mlrf_pkg.
module mlrf_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mlrf_pkg::sums_t data_i,
  input  logic            pop_i,
  output mlrf_pkg::sums_t data_o,
  output mlrf_pkg::qstat_t stat_o
);
  localparam int AW = $clog2(mlrf_pkg::QDEPTH);

  mlrf_pkg::sums_t mem_q [mlrf_pkg::QDEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [AW:0] cnt_q;

  assign stat_o.full = (cnt_q == (AW+1)'(mlrf_pkg::QDEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign data_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + AW'(1);
      if (pop_i) rd_q <= rd_q + AW'(1);
      if (push_i && !pop_i) cnt_q <= cnt_q + (AW+1)'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end
endmodule

### sv/mlrf_solver.sv
// Back end: forms det and numerators with a shared 26x26 multiplier, then
// divides bit-serially into Q16.16 with rounding and saturation. Uses mlrf_pkg.
module mlrf_solver (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mlrf_pkg::sums_t  job_i,
  input  mlrf_pkg::qstat_t qstat_i,
  output logic             q_pop_o,
  output logic             empty_o,
  input  logic             pop_i,
  output logic signed [mlrf_pkg::OUT_W-1:0] fit_offset_o,
  output logic signed [mlrf_pkg::OUT_W-1:0] fit_gain_o,
  output logic             singular_o
);
  localparam int AW = mlrf_pkg::ACC_W;
  localparam int SW = mlrf_pkg::SUM2_W;
  localparam int LW = mlrf_pkg::LIMB_W;
  localparam int DW = mlrf_pkg::DET_W;
  localparam int NW = mlrf_pkg::DIVN_W;
  localparam int OW = mlrf_pkg::OUT_W;
  localparam int BW = $clog2(NW);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MUL  = 7'b0000010,
    S_ADD  = 7'b0000100,
    S_CHK  = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_RND  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  mlrf_pkg::sums_t job_q;
  logic [2:0] prod_q;
  logic [1:0] part_q;
  logic [2*LW-1:0] pp_q;
  logic neg_q;
  logic signed [AW-1:0] det_q, n1_q, n0_q;
  logic [DW-1:0] dmag_q, rem_q;
  logic [NW-1:0] dvd_q, quo_q;
  logic [BW-1:0] bit_q;
  logic sel_q, qneg_q, sing_w_q;
  logic [OW-1:0] off_w_q, gain_w_q;
  logic out_vld_q;

  logic signed [SW-1:0] opa, opb;
  logic [SW-1:0] maga, magb;
  logic [LW-1:0] limba, limbb;
  logic [AW-1:0] addv;
  logic signed [AW-1:0] num, nmag;
  logic [DW:0] rsh, rsub;
  logic [NW:0] qinc;
  logic [NW-1:0] qr;
  logic [OW-1:0] qres;

  always_comb begin
    case (prod_q)
      3'd0: begin
        opa = SW'($signed({1'b0, job_q.n}));
        opb = job_q.sff;
      end
      3'd1: begin
        opa = SW'(job_q.sf);
        opb = SW'(job_q.sf);
      end
      3'd2: begin
        opa = SW'($signed({1'b0, job_q.n}));
        opb = job_q.sfz;
      end
      3'd3: begin
        opa = SW'(job_q.sf);
        opb = SW'(job_q.sz);
      end
      3'd4: begin
        opa = job_q.sff;
        opb = SW'(job_q.sz);
      end
      default: begin
        opa = SW'(job_q.sf);
        opb = job_q.sfz;
      end
    endcase
    maga = opa[SW-1] ? SW'(-opa) : SW'(opa);
    magb = opb[SW-1] ? SW'(-opb) : SW'(opb);
    limba = part_q[1] ? maga[SW-1:LW] : maga[LW-1:0];
    limbb = part_q[0] ? magb[SW-1:LW] : magb[LW-1:0];
  end

  always_comb begin
    case (part_q)
      2'd0: addv = AW'(pp_q);
      2'd3: addv = AW'(pp_q) << (2 * LW);
      default: addv = AW'(pp_q) << LW;
    endcase
  end

  always_comb begin
    num = sel_q ? n1_q : n0_q;
    nmag = num[AW-1] ? -num : num;
    rsh = {rem_q, dvd_q[NW-1]};
    rsub = rsh - {1'b0, dmag_q};
    qinc = {1'b0, quo_q} + (NW+1)'(1);
    qr = qinc[NW:1];
    if (qr == '0) begin
      qres = '0;
    end else if (qneg_q) begin
      if (qr > NW'(64'h8000_0000)) qres = 32'h8000_0000;
      else qres = OW'(-qr);
    end else begin
      if (qr > NW'(64'h7FFF_FFFF)) qres = 32'h7FFF_FFFF;
      else qres = qr[OW-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (!qstat_i.empty) state_d = S_MUL;
      S_MUL:  state_d = S_ADD;
      S_ADD:  if (part_q == 2'd3 && prod_q == 3'd5) state_d = S_CHK;
              else state_d = S_MUL;
      S_CHK:  state_d = (det_q == '0) ? S_DONE : S_DIV;
      S_DIV:  if (bit_q == BW'(NW - 1)) state_d = S_RND;
      S_RND:  state_d = sel_q ? S_DONE : S_DIV;
      S_DONE: if (!out_vld_q) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign q_pop_o = (state_q == S_IDLE) && !qstat_i.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_DONE && !out_vld_q) out_vld_q <= 1'b1;
      else if (pop_i && out_vld_q) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        job_q <= job_i;
        prod_q <= '0;
        part_q <= '0;
        det_q <= '0;
        n1_q <= '0;
        n0_q <= '0;
        sel_q <= 1'b0;
      end
      S_MUL: begin
        pp_q <= limba * limbb;
        neg_q <= opa[SW-1] ^ opb[SW-1] ^ prod_q[0];
      end
      S_ADD: begin
        case (prod_q[2:1])
          2'd0: det_q <= neg_q ? det_q - $signed(addv) : det_q + $signed(addv);
          2'd1: n1_q <= neg_q ? n1_q - $signed(addv) : n1_q + $signed(addv);
          default: n0_q <= neg_q ? n0_q - $signed(addv) : n0_q + $signed(addv);
        endcase
        part_q <= part_q + 2'd1;
        if (part_q == 2'd3) prod_q <= prod_q + 3'd1;
      end
      S_CHK: begin
        sing_w_q <= (det_q == '0);
        off_w_q <= '0;
        gain_w_q <= '0;
        dmag_q <= det_q[AW-1] ? DW'(-det_q) : DW'(det_q);
        dvd_q <= {nmag[mlrf_pkg::NUM_MAG_W-1:0], (mlrf_pkg::FRAC_W+1)'(0)};
        qneg_q <= num[AW-1] ^ det_q[AW-1];
        rem_q <= '0;
        quo_q <= '0;
        bit_q <= '0;
      end
      S_DIV: begin
        dvd_q <= dvd_q << 1;
        bit_q <= bit_q + BW'(1);
        if (!rsub[DW]) begin
          rem_q <= rsub[DW-1:0];
          quo_q <= {quo_q[NW-2:0], 1'b1};
        end else begin
          rem_q <= rsh[DW-1:0];
          quo_q <= {quo_q[NW-2:0], 1'b0};
        end
      end
      S_RND: begin
        if (sel_q) gain_w_q <= qres;
        else off_w_q <= qres;
        sel_q <= 1'b1;
        dvd_q <= {(mlrf_pkg::NUM_MAG_W)'(n1_q[AW-1] ? -n1_q : n1_q),
                  (mlrf_pkg::FRAC_W+1)'(0)};
        qneg_q <= n1_q[AW-1] ^ det_q[AW-1];
        rem_q <= '0;
        quo_q <= '0;
        bit_q <= '0;
      end
      S_DONE: begin
        if (!out_vld_q) begin
          fit_offset_o <= off_w_q;
          fit_gain_o <= gain_w_q;
          singular_o <= sing_w_q;
        end
      end
      default: ;
    endcase
  end

  assign empty_o = !out_vld_q;
endmodule

### sv/masked_linear_regression_fit_unit.sv
// Top level of the masked linear regression fit unit.
// Instantiates mlrf_front, mlrf_queue and mlrf_solver; uses mlrf_pkg.
//
// channel   signals                               direction
// pixels    push_i full_o model/data_pixel_i      in
// results   pop_i empty_o fit_offset/gain/sing    out
// config    cfg_valid_i cfg_ready_o index data    in
//
// Pixels are taken one per cycle while full_o is low; the accumulators sit behind
// one product stage. The solver forms each frame's det and numerators with the
// shared 26x26 multiplier, then divides them in the bit-serial divider.
// Two frame snapshots queue ahead of the solver; full_o rises only when the
// queue is full on a frame's last pixel. Reset is asynchronous, active low,
// and restores the register defaults; a config write restarts the frame.
module masked_linear_regression_fit_unit (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  output logic full_o,
  input  logic signed [mlrf_pkg::PIX_W-1:0] model_pixel_i,
  input  logic signed [mlrf_pkg::PIX_W-1:0] data_pixel_i,
  input  logic pop_i,
  output logic empty_o,
  output logic signed [mlrf_pkg::OUT_W-1:0] fit_offset_o,
  output logic signed [mlrf_pkg::OUT_W-1:0] fit_gain_o,
  output logic singular_o,
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [mlrf_pkg::CFG_W-1:0] cfg_data_i
);
  logic [mlrf_pkg::CFG_W-1:0] width_q, height_q;
  logic [mlrf_pkg::HALF_W-1:0] half_q;
  logic cfg_hit, q_push, q_pop;
  mlrf_pkg::sums_t q_in, q_out;
  mlrf_pkg::qstat_t qstat;

  assign cfg_ready_o = 1'b1;
  assign cfg_hit = cfg_valid_i && (cfg_index_i == mlrf_pkg::REG_WIDTH ||
                   cfg_index_i == mlrf_pkg::REG_HEIGHT || cfg_index_i == mlrf_pkg::REG_HALF);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= mlrf_pkg::RST_WIDTH;
      height_q <= mlrf_pkg::RST_HEIGHT;
      half_q <= mlrf_pkg::RST_HALF;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        mlrf_pkg::REG_WIDTH:  width_q <= cfg_data_i;
        mlrf_pkg::REG_HEIGHT: height_q <= cfg_data_i;
        mlrf_pkg::REG_HALF:   half_q <= cfg_data_i[mlrf_pkg::HALF_W-1:0];
        default: ;
      endcase
    end
  end

  mlrf_front u_front (
    .clk_i, .rst_ni, .clear_i(cfg_hit),
    .width_i(width_q), .height_i(height_q), .half_i(half_q),
    .push_i, .full_o, .model_pixel_i, .data_pixel_i,
    .qstat_i(qstat), .q_push_o(q_push), .q_data_o(q_in)
  );

  mlrf_queue u_queue (
    .clk_i, .rst_ni, .push_i(q_push), .data_i(q_in),
    .pop_i(q_pop), .data_o(q_out), .stat_o(qstat)
  );

  mlrf_solver u_solver (
    .clk_i, .rst_ni, .job_i(q_out), .qstat_i(qstat), .q_pop_o(q_pop),
    .empty_o, .pop_i, .fit_offset_o, .fit_gain_o, .singular_o
  );

  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && singular_o) |-> (fit_offset_o == '0 && fit_gain_o == '0))
    else $error("singular result with nonzero fit");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !qstat.full) else $error("snapshot queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !qstat.empty) else $error("snapshot queue underflow");
endmodule
